FILE: rtl/bmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmt_pkg
// Types, command codes and segment tables shared by the mm:ss timer blocks.
// ----------------------------------------------------------------------------
package bmt_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_DOWN = 2'd1,
    CMD_UP   = 2'd2,
    CMD_ICON = 2'd3
  } bmt_cmd_e;

  localparam logic [1:0] ICON_DOWN  = 2'd0;
  localparam logic [1:0] ICON_UP    = 2'd1;
  localparam logic [1:0] ICON_ENTRY = 2'd2;

  localparam logic [11:0] MAX_INTERVAL = 12'd3599;

  // Icon symbols for the two right-hand digits.
  localparam logic [7:0] ICON_DOWN_L  = 8'hCE;
  localparam logic [7:0] ICON_DOWN_R  = 8'h2A;
  localparam logic [7:0] ICON_UP_L    = 8'hC4;
  localparam logic [7:0] ICON_UP_R    = 8'hCE;
  localparam logic [7:0] ICON_ENTRY_L = 8'h7A;
  localparam logic [7:0] ICON_ENTRY_R = 8'hF6;

  typedef struct packed {
    bmt_cmd_e    command;
    logic [11:0] interval_seconds;
    logic [1:0]  icon;
  } bmt_in_t;

  typedef struct packed {
    logic [7:0] seg_minutes_tens;
    logic [7:0] seg_minutes_units;
    logic [7:0] seg_seconds_tens;
    logic [7:0] seg_seconds_units;
    logic       display_update;
    logic       finished;
    logic       running;
  } bmt_out_t;

  // Item as held in the input register, with the interval already in digits.
  typedef struct packed {
    bmt_cmd_e    command;
    logic [1:0]  icon;
    logic [11:0] ticks;
    logic [2:0]  min_tens;
    logic [3:0]  min_units;
    logic [2:0]  sec_tens;
    logic [3:0]  sec_units;
  } bmt_item_t;

  function automatic logic [7:0] seg_digit(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hFC;
      4'd1:    s = 8'h60;
      4'd2:    s = 8'hDA;
      4'd3:    s = 8'hF2;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'hB6;
      4'd6:    s = 8'hBE;
      4'd7:    s = 8'hE0;
      4'd8:    s = 8'hFE;
      4'd9:    s = 8'hE6;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Patterns for a digit mounted upside down.
  function automatic logic [7:0] seg_digit_inv(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hFC;
      4'd1:    s = 8'h0C;
      4'd2:    s = 8'hDA;
      4'd3:    s = 8'h9E;
      4'd4:    s = 8'h2E;
      4'd5:    s = 8'hB6;
      4'd6:    s = 8'hF6;
      4'd7:    s = 8'h1C;
      4'd8:    s = 8'hFE;
      4'd9:    s = 8'h3E;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bmt_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmt_split
// Saturates an interval in seconds and splits it into four mm:ss digits.
// ----------------------------------------------------------------------------
module bmt_split import bmt_pkg::*; (
  input  bmt_in_t   in_data_i,
  output bmt_item_t item_o
);

  logic [11:0] sat;
  logic [2:0]  mt;
  logic [11:0] r1;
  logic [3:0]  mu;
  logic [9:0]  r2;
  logic [2:0]  st;
  logic [5:0]  r3;

  // Each digit is found by comparing against constant multiples and
  // subtracting the chosen one; no general divider is needed.
  always_comb begin
    sat = (in_data_i.interval_seconds > MAX_INTERVAL) ? MAX_INTERVAL
                                                      : in_data_i.interval_seconds;
    if      (sat >= 12'd3000) mt = 3'd5;
    else if (sat >= 12'd2400) mt = 3'd4;
    else if (sat >= 12'd1800) mt = 3'd3;
    else if (sat >= 12'd1200) mt = 3'd2;
    else if (sat >= 12'd600)  mt = 3'd1;
    else                      mt = 3'd0;
    r1 = sat - (12'(mt) * 12'd600);

    if      (r1 >= 12'd540) mu = 4'd9;
    else if (r1 >= 12'd480) mu = 4'd8;
    else if (r1 >= 12'd420) mu = 4'd7;
    else if (r1 >= 12'd360) mu = 4'd6;
    else if (r1 >= 12'd300) mu = 4'd5;
    else if (r1 >= 12'd240) mu = 4'd4;
    else if (r1 >= 12'd180) mu = 4'd3;
    else if (r1 >= 12'd120) mu = 4'd2;
    else if (r1 >= 12'd60)  mu = 4'd1;
    else                    mu = 4'd0;
    r2 = r1[9:0] - (10'(mu) * 10'd60);

    if      (r2 >= 10'd50) st = 3'd5;
    else if (r2 >= 10'd40) st = 3'd4;
    else if (r2 >= 10'd30) st = 3'd3;
    else if (r2 >= 10'd20) st = 3'd2;
    else if (r2 >= 10'd10) st = 3'd1;
    else                   st = 3'd0;
    r3 = r2[5:0] - (6'(st) * 6'd10);

    item_o.command   = in_data_i.command;
    item_o.icon      = in_data_i.icon;
    item_o.ticks     = sat;
    item_o.min_tens  = mt;
    item_o.min_units = mu;
    item_o.sec_tens  = st;
    item_o.sec_units = r3[3:0];
  end

endmodule
`default_nettype wire

FILE: rtl/bmt_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmt_core
// Timer state and the combinational update that forms one result per item.
// ----------------------------------------------------------------------------
module bmt_core import bmt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  bmt_item_t item_i,
  output bmt_out_t  result_o
);

  logic [2:0]  mt_q, mt_d;
  logic [3:0]  mu_q, mu_d;
  logic [2:0]  st_q, st_d;
  logic [3:0]  su_q, su_d;
  logic [11:0] ticks_q, ticks_d;
  logic        running_q, running_d;
  logic        done_q, done_d;

  always_comb begin
    mt_d      = mt_q;
    mu_d      = mu_q;
    st_d      = st_q;
    su_d      = su_q;
    ticks_d   = ticks_q;
    running_d = running_q;
    done_d    = done_q;
    result_o  = '0;

    case (item_i.command)
      CMD_LOAD: begin
        if (!running_q) begin
          mt_d      = item_i.min_tens;
          mu_d      = item_i.min_units;
          st_d      = item_i.sec_tens;
          su_d      = item_i.sec_units;
          ticks_d   = item_i.ticks;
          running_d = 1'b1;
          done_d    = 1'b0;
        end
      end
      CMD_DOWN: begin
        // The time shown is the one before this tick.
        result_o.seg_minutes_tens  = seg_digit({1'b0, mt_q});
        result_o.seg_minutes_units = seg_digit(mu_q) | 8'h01;
        result_o.seg_seconds_tens  = seg_digit_inv({1'b0, st_q}) | 8'h01;
        result_o.seg_seconds_units = seg_digit(su_q);
        result_o.display_update    = 1'b1;
        ticks_d = ticks_q - 12'd1;
        done_d  = done_q | (ticks_d == 12'd0);
        if (done_d) begin
          running_d = 1'b0;
        end else if (su_q != 4'd0) begin
          su_d = su_q - 4'd1;
        end else if (st_q != 3'd0) begin
          st_d = st_q - 3'd1;
          su_d = 4'd9;
        end else if (mu_q != 4'd0) begin
          mu_d = mu_q - 4'd1;
          st_d = 3'd5;
          su_d = 4'd9;
        end else if (mt_q != 3'd0) begin
          mt_d = mt_q - 3'd1;
          mu_d = 4'd9;
          st_d = 3'd5;
          su_d = 4'd9;
        end else begin
          // Already at zero: flag the end but leave the running flag alone.
          done_d = 1'b1;
        end
      end
      CMD_UP: begin
        su_d = su_q + 4'd1;
        if (su_d > 4'd9) begin
          su_d = 4'd0;
          st_d = st_q + 3'd1;
        end
        if (st_d > 3'd5) begin
          st_d = 3'd0;
          mu_d = mu_q + 4'd1;
        end
        if (mu_d > 4'd9) begin
          mu_d = 4'd0;
          mt_d = mt_q + 3'd1;
        end
        if (mt_d > 3'd5) begin
          mt_d = 3'd0;
        end
        result_o.seg_minutes_tens  = seg_digit({1'b0, mt_d});
        result_o.seg_minutes_units = seg_digit(mu_d);
        result_o.seg_seconds_tens  = seg_digit_inv({1'b0, st_d});
        result_o.seg_seconds_units = seg_digit(su_d);
        result_o.display_update    = 1'b1;
      end
      CMD_ICON: begin
        case (item_i.icon)
          ICON_DOWN: begin
            result_o.seg_seconds_tens  = ICON_DOWN_L;
            result_o.seg_seconds_units = ICON_DOWN_R;
            result_o.display_update    = 1'b1;
          end
          ICON_UP: begin
            result_o.seg_seconds_tens  = ICON_UP_L;
            result_o.seg_seconds_units = ICON_UP_R;
            result_o.display_update    = 1'b1;
          end
          ICON_ENTRY: begin
            result_o.seg_seconds_tens  = ICON_ENTRY_L;
            result_o.seg_seconds_units = ICON_ENTRY_R;
            result_o.display_update    = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    result_o.finished = done_d;
    result_o.running  = running_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mt_q      <= '0;
      mu_q      <= '0;
      st_q      <= '0;
      su_q      <= '0;
      ticks_q   <= '0;
      running_q <= 1'b0;
      done_q    <= 1'b0;
    end else if (fire_i) begin
      mt_q      <= mt_d;
      mu_q      <= mu_d;
      st_q      <= st_d;
      su_q      <= su_d;
      ticks_q   <= ticks_d;
      running_q <= running_d;
      done_q    <= done_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bcd_mmss_up_down_timer_display.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_mmss_up_down_timer_display
// BCD mm:ss up/down timer producing four seven-segment bytes per item.
// ----------------------------------------------------------------------------
//  Channel | Handshake             | Payload
//  --------+-----------------------+------------------------
//  in      | in_valid_i/in_ready_o | in_data_i  (bmt_in_t)
//  out     | out_valid_o/out_ready_i | out_data_o (bmt_out_t)
//
// One item is taken every cycle while the result is not stalled; the item is held in
// the input register and its result in the result register before it is offered.
// The interval is split into digits before the input register; the state
// update and segment encoding sit between the input and result registers.
// Reset clears both valid flags and the timer state to 00:00, idle.
// While the result is stalled the input register still takes one more item.
// ----------------------------------------------------------------------------
module bcd_mmss_up_down_timer_display import bmt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bmt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bmt_out_t out_data_o
);

  bmt_item_t split_item;
  bmt_item_t item_q;
  logic      in_valid_q, in_valid_d;
  bmt_out_t  result;
  bmt_out_t  out_q;
  logic      out_valid_q, out_valid_d;
  logic      advance;

  bmt_split u_split (
    .in_data_i (in_data_i),
    .item_o    (split_item)
  );

  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;

  bmt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (item_q),
    .result_o (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= split_item;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: rtl/bmt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmt_checker
// Port-level checks on the timer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bmt_checker import bmt_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input bmt_out_t out_data_o
);

  // A stalled item stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result item changed while stalled");

  // Items that do not refresh the display carry blank segment bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.display_update |->
      out_data_o.seg_minutes_tens == 8'h00 && out_data_o.seg_minutes_units == 8'h00 &&
      out_data_o.seg_seconds_tens == 8'h00 && out_data_o.seg_seconds_units == 8'h00)
    else $error("blank item carries segment data");

  // Decimal points appear on both middle digits or on neither, never on the leftmost digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.seg_minutes_units[0] == out_data_o.seg_seconds_tens[0] &&
      !out_data_o.seg_minutes_tens[0])
    else $error("decimal points inconsistent");

endmodule

bind bcd_mmss_up_down_timer_display bmt_checker u_bmt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
